[src/bsr_pkg.sv]
`default_nettype none

package bsr_pkg;

    localparam int DEF_MAX_COLS = 32;
    localparam int DEF_MAX_ROWS = 32;

    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 1;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 6;

    localparam int ROW_BITS_W  = 32;
    localparam int ROW_INDEX_W = 5;
    localparam int COORD_W     = 7;
    localparam int SIZE_W      = 6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COLS = 1'b0,
        CFG_ROWS = 1'b1
    } cfg_index_t;

    typedef enum logic [S_TUSER_W-1:0] {
        CMD_SQUARE   = 2'd0,
        CMD_LINE     = 2'd1,
        CMD_TRIANGLE = 2'd2
    } cmd_t;

endpackage

`default_nettype wire

[src/bitmap_shape_rasterizer_top.sv]
// Bitmap shape rasteriser.
// Holds a one-bit canvas of up to 32 x 32 cells. Each item on the s_ channel is
// one drawing command (square, line or right triangle). The shape is bounds
// checked; a failing shape yields one item on the m_ channel with tuser set and
// tlast set. A passing shape is ORed into the canvas and every row in use is
// then sent as one item, top row first, tlast on the final row.
// The cfg channel sets the column and row counts; it is always ready. It must
// only be written while no command is in progress; the block does not enforce this.
// Steps: the sequencer takes the item, checks it and dispatches it to its
// drawing loop (one span per row for a square or triangle, one cell at a time
// for a line), then sends the rows one by one; a rejected shape goes from the
// check straight to the error item.
// s_tready is high only while the sequencer waits for a command.
// When the receiver stalls, the output register holds its item and the
// sequencer waits on that row; no item is lost or repeated.
// Reset clears the canvas and sets both counts to 32.
`default_nettype none

module bitmap_shape_rasterizer_top #(
    parameter int MAX_COLS = bsr_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = bsr_pkg::DEF_MAX_ROWS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // size[5:0], pos_x[12:6], pos_y[19:13], end_x[26:20], end_y[33:27], facing[35:34]
    input  wire logic [bsr_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd[1:0]
    input  wire logic [bsr_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // row_bits[31:0], row_index[36:32]
    output logic [bsr_pkg::M_TDATA_W-1:0]        m_tdata,
    // out_of_range[0]
    output logic [bsr_pkg::M_TUSER_W-1:0]        m_tuser,
    // last
    output logic                                 m_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bsr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bsr_pkg::*;

    localparam int CANVAS_COLS = (MAX_COLS < ROW_BITS_W) ? MAX_COLS : ROW_BITS_W;
    localparam int CANVAS_ROWS = (MAX_ROWS < (1 << ROW_INDEX_W)) ? MAX_ROWS
                                                                 : (1 << ROW_INDEX_W);
    localparam int ROW_AW = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
    localparam int M_PAD_W = M_TDATA_W - ROW_BITS_W - ROW_INDEX_W;
    localparam logic [CFG_DATA_W-1:0] COLS_LIM = CFG_DATA_W'(CANVAS_COLS);
    localparam logic [CFG_DATA_W-1:0] ROWS_LIM = CFG_DATA_W'(CANVAS_ROWS);
    localparam logic [CFG_DATA_W-1:0] DIM_RESET = CFG_DATA_W'(32);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_SEL, ST_SPAN, ST_LINE, ST_ROWS, ST_ERR
    } step_t;

    typedef enum logic [2:0] {
        CND_NO_INPUT, CND_BAD, CND_IS_LINE, CND_SPAN_MORE,
        CND_LINE_MORE, CND_ROW_HOLD, CND_OUT_BUSY
    } cond_t;

    typedef enum logic [2:0] {
        OP_LOAD, OP_INIT, OP_NONE, OP_SPAN, OP_LINE, OP_EMIT_ROW, OP_EMIT_ERR
    } op_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jump;
        step_t next;
    } uword_t;

    function automatic uword_t ucode(input step_t s);
        uword_t w;
        unique case (s)
            ST_IDLE:  w = '{OP_LOAD,     CND_NO_INPUT,  ST_IDLE, ST_CHECK};
            ST_CHECK: w = '{OP_INIT,     CND_BAD,       ST_ERR,  ST_SEL};
            ST_SEL:   w = '{OP_NONE,     CND_IS_LINE,   ST_LINE, ST_SPAN};
            ST_SPAN:  w = '{OP_SPAN,     CND_SPAN_MORE, ST_SPAN, ST_ROWS};
            ST_LINE:  w = '{OP_LINE,     CND_LINE_MORE, ST_LINE, ST_ROWS};
            ST_ROWS:  w = '{OP_EMIT_ROW, CND_ROW_HOLD,  ST_ROWS, ST_IDLE};
            ST_ERR:   w = '{OP_EMIT_ERR, CND_OUT_BUSY,  ST_ERR,  ST_IDLE};
            default:  w = '{OP_NONE,     CND_NO_INPUT,  ST_IDLE, ST_IDLE};
        endcase
        return w;
    endfunction

    step_t                         step_reg;
    logic [S_TUSER_W-1:0]          cmd_reg;
    logic [SIZE_W-1:0]             size_reg;
    logic signed [COORD_W-1:0]     x_reg;
    logic signed [COORD_W-1:0]     y_reg;
    logic signed [COORD_W-1:0]     ex_reg;
    logic signed [COORD_W-1:0]     ey_reg;
    logic [1:0]                    facing_reg;
    logic [SIZE_W-1:0]             cnt_reg;
    logic [ROW_AW-1:0]             row_cnt_reg;
    logic [CFG_DATA_W-1:0]         cols_reg;
    logic [CFG_DATA_W-1:0]         rows_reg;
    logic [CANVAS_COLS-1:0]        canvas_reg [CANVAS_ROWS];
    logic                          m_tvalid_reg;
    logic [ROW_BITS_W-1:0]         out_bits_reg;
    logic [ROW_INDEX_W-1:0]        out_index_reg;
    logic                          out_err_reg;
    logic                          out_last_reg;

    uword_t                 uw;
    step_t                  step_next;
    logic                   accept;
    logic                   out_free;
    logic                   cond_hit;
    logic                   shape_ok;
    logic                   left;
    logic                   up;
    logic                   last_row;
    logic                   draw_en;
    logic [CFG_DATA_W-1:0]  cols_eff;
    logic [CFG_DATA_W-1:0]  rows_eff;
    logic [ROW_AW-1:0]      rows_m1;
    logic signed [8:0]      xs, ys, exs, eys, szs, cnts, lens, cols_s, rows_s;
    logic signed [8:0]      fx, fy, draw_row, span_a, span_b;
    logic [CANVAS_COLS-1:0] span_mask;
    logic [CANVAS_COLS-1:0] col_mask;

    assign uw       = ucode(step_reg);
    assign s_tready = (step_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign left     = !facing_reg[1];
    assign up       = !facing_reg[0];

    always_comb begin
        priority if (cols_reg == '0) begin
            cols_eff = CFG_DATA_W'(1);
        end else if (cols_reg > COLS_LIM) begin
            cols_eff = COLS_LIM;
        end else begin
            cols_eff = cols_reg;
        end
        priority if (rows_reg == '0) begin
            rows_eff = CFG_DATA_W'(1);
        end else if (rows_reg > ROWS_LIM) begin
            rows_eff = ROWS_LIM;
        end else begin
            rows_eff = rows_reg;
        end
    end

    assign rows_m1  = ROW_AW'(rows_eff - CFG_DATA_W'(1));
    assign last_row = (row_cnt_reg == rows_m1);

    always_comb begin
        xs     = 9'(x_reg);
        ys     = 9'(y_reg);
        exs    = 9'(ex_reg);
        eys    = 9'(ey_reg);
        szs    = $signed({3'b000, size_reg});
        cnts   = $signed({3'b000, cnt_reg});
        lens   = szs - cnts;
        cols_s = $signed({3'b000, cols_eff});
        rows_s = $signed({3'b000, rows_eff});
        fx     = left ? xs - szs + 9'sd1 : xs + szs - 9'sd1;
        fy     = up ? ys - szs + 9'sd1 : ys + szs - 9'sd1;
        unique case (cmd_reg)
            CMD_SQUARE: begin
                shape_ok = xs >= 9'sd0 && ys >= 9'sd0 &&
                           xs + szs <= cols_s && ys + szs <= rows_s;
            end
            CMD_LINE: begin
                shape_ok = xs >= 9'sd0 && xs < cols_s && exs >= 9'sd0 && exs < cols_s &&
                           ys >= 9'sd0 && ys < rows_s && eys >= 9'sd0 && eys < rows_s;
            end
            CMD_TRIANGLE: begin
                shape_ok = xs >= 9'sd0 && xs < cols_s && ys >= 9'sd0 && ys < rows_s &&
                           (left ? fx >= 9'sd0 : fx < cols_s) &&
                           (up ? fy >= 9'sd0 : fy < rows_s);
            end
            default: begin
                shape_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (uw.op == OP_LINE) begin
            draw_row = ys;
            span_a   = xs;
            span_b   = xs;
        end else if (cmd_reg == CMD_TRIANGLE) begin
            draw_row = up ? ys - cnts : ys + cnts;
            span_a   = left ? xs - lens + 9'sd1 : xs;
            span_b   = left ? xs : xs + lens - 9'sd1;
        end else begin
            draw_row = ys + cnts;
            span_a   = xs;
            span_b   = xs + szs - 9'sd1;
        end
        for (int j = 0; j < CANVAS_COLS; j++) begin
            span_mask[j] = (9'(j) >= span_a) && (9'(j) <= span_b);
            col_mask[j]  = CFG_DATA_W'(j) < cols_eff;
        end
    end

    assign draw_en = (uw.op == OP_SPAN && cnt_reg != size_reg) || uw.op == OP_LINE;

    always_comb begin
        unique case (uw.cond)
            CND_NO_INPUT:  cond_hit = !s_tvalid;
            CND_BAD:       cond_hit = !shape_ok;
            CND_IS_LINE:   cond_hit = (cmd_reg == CMD_LINE);
            CND_SPAN_MORE: cond_hit = (cnt_reg != size_reg);
            CND_LINE_MORE: cond_hit = !(x_reg == ex_reg && y_reg == ey_reg);
            CND_ROW_HOLD:  cond_hit = !out_free || !last_row;
            CND_OUT_BUSY:  cond_hit = !out_free;
            default:       cond_hit = 1'b0;
        endcase
        step_next = cond_hit ? uw.jump : uw.next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cols_reg     <= DIM_RESET;
            rows_reg     <= DIM_RESET;
            for (int i = 0; i < CANVAS_ROWS; i++) begin
                canvas_reg[i] <= '0;
            end
        end else begin
            step_reg <= step_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_COLS: cols_reg <= cfg_data;
                    CFG_ROWS: rows_reg <= cfg_data;
                endcase
            end
            for (int i = 0; i < CANVAS_ROWS; i++) begin
                if (draw_en && draw_row == 9'(i)) begin
                    canvas_reg[i] <= canvas_reg[i] | span_mask;
                end
            end
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (uw.op)
                OP_LOAD: begin
                    if (accept) begin
                        cmd_reg    <= s_tuser;
                        size_reg   <= s_tdata[5:0];
                        x_reg      <= s_tdata[12:6];
                        y_reg      <= s_tdata[19:13];
                        ex_reg     <= s_tdata[26:20];
                        ey_reg     <= s_tdata[33:27];
                        facing_reg <= s_tdata[35:34];
                    end
                end
                OP_INIT: begin
                    cnt_reg     <= '0;
                    row_cnt_reg <= '0;
                end
                OP_SPAN: begin
                    if (cnt_reg != size_reg) begin
                        cnt_reg <= cnt_reg + SIZE_W'(1);
                    end
                end
                OP_LINE: begin
                    if (x_reg != ex_reg) begin
                        x_reg <= (ex_reg > x_reg) ? x_reg + 7'sd1 : x_reg - 7'sd1;
                    end
                    if (y_reg != ey_reg) begin
                        y_reg <= (ey_reg > y_reg) ? y_reg + 7'sd1 : y_reg - 7'sd1;
                    end
                end
                OP_EMIT_ROW: begin
                    if (out_free) begin
                        m_tvalid_reg  <= 1'b1;
                        out_bits_reg  <= ROW_BITS_W'(canvas_reg[row_cnt_reg] & col_mask);
                        out_index_reg <= ROW_INDEX_W'(row_cnt_reg);
                        out_err_reg   <= 1'b0;
                        out_last_reg  <= last_row;
                        row_cnt_reg   <= row_cnt_reg + ROW_AW'(1);
                    end
                end
                OP_EMIT_ERR: begin
                    if (out_free) begin
                        m_tvalid_reg  <= 1'b1;
                        out_bits_reg  <= '0;
                        out_index_reg <= '0;
                        out_err_reg   <= 1'b1;
                        out_last_reg  <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {M_PAD_W'(0), out_index_reg, out_bits_reg};
    assign m_tuser   = out_err_reg;
    assign m_tlast   = out_last_reg;

endmodule

`default_nettype wire

[src/bsr_checker.sv]
`default_nettype none

module bsr_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [bsr_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [bsr_pkg::M_TUSER_W-1:0] m_tuser,
    input wire logic                          m_tlast
);

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Output item changed while stalled.");

    a_err_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == '0)
        else $error("Out-of-range item is not a lone, empty final item.");

    a_busy_no_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("Input taken while rows of a command were still pending.");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output item present straight after reset.");

endmodule

bind bitmap_shape_rasterizer_top bsr_checker u_bsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[verif/tb_bitmap_shape_rasterizer_top.sv]
`timescale 1ns / 100ps

module tb_bitmap_shape_rasterizer_top;
    import bsr_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] FACE_LU = 2'd0;
    localparam logic [1:0] FACE_LD = 2'd1;
    localparam logic [1:0] FACE_RU = 2'd2;
    localparam logic [1:0] FACE_RD = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER = 200;
    localparam int MAX_REPORTS = 40;
    localparam int NUM_PHASES = 7;

    typedef struct {
        logic [1:0]        cmd;
        logic [5:0]        size;
        logic signed [6:0] pos_x;
        logic signed [6:0] pos_y;
        logic signed [6:0] end_x;
        logic signed [6:0] end_y;
        logic [1:0]        facing;
    } draw_cmd_t;

    typedef struct {
        logic [31:0] row_bits;
        logic [4:0]  row_index;
        logic        out_of_range;
        logic        last;
    } row_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    wire                    s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    wire                    m_tvalid;
    logic                   m_tready = 1'b0;
    wire  [M_TDATA_W-1:0]   m_tdata;
    wire  [M_TUSER_W-1:0]   m_tuser;
    wire                    m_tlast;
    logic                   cfg_valid = 1'b0;
    wire                    cfg_ready;
    cfg_index_t             cfg_index = CFG_COLS;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic [31:0] canvas_img [32];
    logic [5:0]  cols_reg = 6'd32;
    logic [5:0]  rows_reg = 6'd32;

    draw_cmd_t   cmds_todo [$];
    row_result_t rows_due [$];
    draw_cmd_t   on_bus;
    row_result_t want;
    logic        sending = 1'b0;
    int          gap_left = 0;
    int          burst_left = 0;
    int          items_taken = 0;
    int          results_seen = 0;
    int          cfg_writes = 0;
    int          errors = 0;
    int          idle_cycles = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    int          rx_mode = 0;
    int          mode_left = 0;
    int          rx_tick = 0;
    logic        rx_ready;

    int ph_cols  [NUM_PHASES] = '{0, 7, 63, 17, 32, 1, 32};
    int ph_rows  [NUM_PHASES] = '{1, 5, 13, 0, 33, 32, 32};
    int ph_items [NUM_PHASES] = '{30, 70, 80, 40, 110, 60, 88};

    bitmap_shape_rasterizer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic void add_cmd(draw_cmd_t d);
        cmds_todo.insert(cmds_todo.size(), d);
    endfunction

    function automatic void add_result(row_result_t res);
        rows_due.insert(rows_due.size(), res);
    endfunction

    function automatic int eff_dim(logic [5:0] count, int bound);
        int v;
        v = count;
        if (v < 1) v = 1;
        if (v > bound) v = bound;
        return v;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_cmd(draw_cmd_t d);
        logic [S_TDATA_W-1:0] v;
        v = '0;
        v[35:0] = {d.facing, d.end_y, d.end_x, d.pos_y, d.pos_x, d.size};
        return v;
    endfunction

    function automatic draw_cmd_t mk(logic [1:0] c, int sz, int x, int y, int x2, int y2,
                                     logic [1:0] f);
        draw_cmd_t d;
        d.cmd = c;
        d.size = 6'(sz);
        d.pos_x = 7'(x);
        d.pos_y = 7'(y);
        d.end_x = 7'(x2);
        d.end_y = 7'(y2);
        d.facing = f;
        return d;
    endfunction

    function automatic void mark_span(int row, int a, int b);
        if (row < 0 || row > 31 || a < 0 || b > 31 || a > b) return;
        for (int c = a; c <= b; c++) canvas_img[row][c] = 1'b1;
    endfunction

    // Draws one command into the canvas image and queues the items it must produce.
    function automatic void draw_and_scan(draw_cmd_t d);
        int cols, rows, x, y, x2, y2, sz, fx, fy, row, len;
        logic ok, left, up, done;
        logic [63:0] m64;
        row_result_t res;
        cols = eff_dim(cols_reg, DEF_MAX_COLS);
        rows = eff_dim(rows_reg, DEF_MAX_ROWS);
        x = d.pos_x;
        y = d.pos_y;
        x2 = d.end_x;
        y2 = d.end_y;
        sz = d.size;
        ok = 1'b0;
        if (d.cmd == CMD_SQUARE) begin
            ok = x >= 0 && y >= 0 && x + sz <= cols && y + sz <= rows;
            if (ok) begin
                for (int k = 0; k < sz; k++) mark_span(y + k, x, x + sz - 1);
            end
        end else if (d.cmd == CMD_LINE) begin
            ok = x >= 0 && x < cols && x2 >= 0 && x2 < cols &&
                 y >= 0 && y < rows && y2 >= 0 && y2 < rows;
            done = !ok;
            while (!done) begin
                mark_span(y, x, x);
                if (x == x2 && y == y2) begin
                    done = 1'b1;
                end else begin
                    if (x != x2) x += (x2 > x) ? 1 : -1;
                    if (y != y2) y += (y2 > y) ? 1 : -1;
                end
            end
        end else if (d.cmd == CMD_TRIANGLE) begin
            left = (d.facing == FACE_LU) || (d.facing == FACE_LD);
            up = (d.facing == FACE_LU) || (d.facing == FACE_RU);
            fx = left ? x - (sz - 1) : x + (sz - 1);
            fy = up ? y - (sz - 1) : y + (sz - 1);
            ok = x >= 0 && x < cols && y >= 0 && y < rows;
            if (ok) ok = (left ? fx >= 0 : fx < cols) && (up ? fy >= 0 : fy < rows);
            if (ok) begin
                for (int k = 0; k < sz; k++) begin
                    row = up ? y - k : y + k;
                    len = sz - k;
                    if (left) mark_span(row, x - len + 1, x);
                    else mark_span(row, x, x + len - 1);
                end
            end
        end
        if (!ok) begin
            res.row_bits = '0;
            res.row_index = '0;
            res.out_of_range = 1'b1;
            res.last = 1'b1;
            add_result(res);
            return;
        end
        m64 = (64'd1 << cols) - 64'd1;
        for (int r = 0; r < rows; r++) begin
            res.row_bits = canvas_img[r] & m64[31:0];
            res.row_index = 5'(r);
            res.out_of_range = 1'b0;
            res.last = (r == rows - 1);
            add_result(res);
        end
    endfunction

    // Most commands are well formed for the current canvas; the rest sit on its edges
    // or are raw noise across every bit of every field.
    function automatic draw_cmd_t random_cmd(int cols, int rows);
        draw_cmd_t d;
        logic [31:0] rnd;
        logic [31:0] rnd2;
        int pick, szmax, sz, s1, x, y;
        pick = $urandom_range(99);
        rnd = $urandom;
        rnd2 = $urandom;
        szmax = (cols < rows) ? cols : rows;
        case ($urandom_range(2))
            0: d.cmd = CMD_SQUARE;
            1: d.cmd = CMD_LINE;
            default: d.cmd = CMD_TRIANGLE;
        endcase
        d.facing = rnd[1:0];
        if (pick < 15) begin
            d.cmd = rnd[3:2];
            d.size = rnd[9:4];
            d.pos_x = rnd[16:10];
            d.pos_y = rnd[23:17];
            d.end_x = rnd[30:24];
            d.end_y = rnd2[6:0];
            d.facing = rnd2[8:7];
        end else if (pick < 30) begin
            d.size = 6'($urandom_range(szmax + 1));
            d.pos_x = 7'(int'($urandom_range(cols + 3)) - 2);
            d.pos_y = 7'(int'($urandom_range(rows + 3)) - 2);
            d.end_x = 7'(int'($urandom_range(cols + 3)) - 2);
            d.end_y = 7'(int'($urandom_range(rows + 3)) - 2);
        end else begin
            if ($urandom_range(7) == 0) sz = $urandom_range(szmax);
            else sz = $urandom_range((szmax < 3) ? szmax : 3);
            s1 = (sz > 0) ? sz - 1 : 0;
            d.size = 6'(sz);
            d.end_x = 7'($urandom_range(cols - 1));
            d.end_y = 7'($urandom_range(rows - 1));
            x = $urandom_range(cols - 1);
            y = $urandom_range(rows - 1);
            if (d.cmd == CMD_SQUARE) begin
                x = $urandom_range(cols - sz);
                y = $urandom_range(rows - sz);
            end else if (d.cmd == CMD_TRIANGLE) begin
                if (d.facing == FACE_LU || d.facing == FACE_LD) x = $urandom_range(cols - 1, s1);
                else x = $urandom_range(cols - 1 - s1);
                if (d.facing == FACE_LU || d.facing == FACE_RU) y = $urandom_range(rows - 1, s1);
                else y = $urandom_range(rows - 1 - s1);
            end
            d.pos_x = 7'(x);
            d.pos_y = 7'(y);
        end
        return d;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want_v);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch at result %0d: %s got 0x%0h, want 0x%0h",
                     results_seen, what, got, want_v);
    endtask

    task automatic cfg_write(cfg_index_t idx, logic [5:0] val);
        int target;
        target = cfg_writes + 1;
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        while (cfg_writes < target) @(posedge aclk);
    endtask

    task automatic settle();
        while (cmds_todo.size() != 0 || sending || rows_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            sending = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                draw_and_scan(on_bus);
                items_taken++;
                sending = 1'b0;
            end
            if (!sending) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmds_todo.size() != 0) begin
                    on_bus = cmds_todo.pop_front();
                    sending = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(12, 1);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1);
                    end
                end
                s_tvalid <= sending;
                s_tdata <= pack_cmd(on_bus);
                s_tuser <= on_bus.cmd;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (rows_due.size() == 0) begin
                report_mismatch("unexpected item", m_tdata[31:0], 0);
            end else begin
                want = rows_due.pop_front();
                if (m_tdata[31:0] !== want.row_bits)
                    report_mismatch("row_bits", m_tdata[31:0], want.row_bits);
                if (m_tdata[36:32] !== want.row_index)
                    report_mismatch("row_index", m_tdata[36:32], want.row_index);
                if (m_tuser[0] !== want.out_of_range)
                    report_mismatch("out_of_range", m_tuser[0], want.out_of_range);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_COLS) cols_reg = cfg_data;
            else rows_reg = cfg_data;
            cfg_writes++;
            cfg_valid <= 1'b0;
        end
    end

    // Once enough items have gone in, the receiver holds off for a long stretch so that
    // the block backs up and stops taking commands.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_tick++;
            if (!hold_done && items_taken >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                rx_mode = $urandom_range(3);
                mode_left = $urandom_range(200, 20);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                rx_ready = 1'b0;
            end else begin
                case (rx_mode)
                    0: rx_ready = 1'b1;
                    1: rx_ready = ($urandom_range(1) == 1);
                    2: rx_ready = ($urandom_range(9) != 0);
                    default: rx_ready = ((rx_tick % 7) >= 3);
                endcase
            end
            m_tready <= rx_ready;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    initial begin
        int cols, rows;
        for (int r = 0; r < 32; r++) canvas_img[r] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        add_cmd(mk(CMD_SQUARE, 0, 0, 0, 0, 0, FACE_LU));
        add_cmd(mk(CMD_SQUARE, 1, 31, 31, 0, 0, FACE_LU));
        add_cmd(mk(CMD_SQUARE, 3, 2, 2, 0, 0, FACE_LU));
        add_cmd(mk(CMD_SQUARE, 1, -1, 4, 0, 0, FACE_LU));
        add_cmd(mk(CMD_SQUARE, 3, 5, 30, 0, 0, FACE_LU));
        add_cmd(mk(CMD_SQUARE, 63, 0, 0, 0, 0, FACE_LU));
        add_cmd(mk(CMD_LINE, 0, 0, 0, 31, 31, FACE_LU));
        add_cmd(mk(CMD_LINE, 0, 31, 0, 0, 31, FACE_LU));
        add_cmd(mk(CMD_LINE, 0, 4, 10, 20, 10, FACE_LU));
        add_cmd(mk(CMD_LINE, 0, 25, 3, 25, 12, FACE_LU));
        add_cmd(mk(CMD_LINE, 0, 5, 20, 5, 20, FACE_LU));
        add_cmd(mk(CMD_LINE, 0, 3, 5, 9, 28, FACE_LU));
        add_cmd(mk(CMD_LINE, 0, 0, 0, 32, 0, FACE_LU));
        add_cmd(mk(CMD_LINE, 0, 0, 0, 0, 32, FACE_LU));
        add_cmd(mk(CMD_LINE, 0, -64, -64, 63, 63, FACE_RD));
        add_cmd(mk(CMD_TRIANGLE, 4, 10, 8, 0, 0, FACE_LU));
        add_cmd(mk(CMD_TRIANGLE, 5, 12, 14, 0, 0, FACE_LD));
        add_cmd(mk(CMD_TRIANGLE, 3, 20, 6, 0, 0, FACE_RU));
        add_cmd(mk(CMD_TRIANGLE, 6, 18, 22, 0, 0, FACE_RD));
        add_cmd(mk(CMD_TRIANGLE, 0, 31, 31, 0, 0, FACE_RD));
        add_cmd(mk(CMD_TRIANGLE, 5, 3, 10, 0, 0, FACE_LU));
        add_cmd(mk(CMD_TRIANGLE, 1, 32, 4, 0, 0, FACE_RU));
        add_cmd(mk(CMD_TRIANGLE, 1, 31, 31, 0, 0, FACE_RD));
        add_cmd(mk(CMD_UNUSED, 2, 1, 1, 2, 2, FACE_LD));
        add_cmd(mk(CMD_SQUARE, 0, 63, 63, -1, -1, FACE_RD));
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            cfg_write(CFG_COLS, 6'(ph_cols[p]));
            cfg_write(CFG_ROWS, 6'(ph_rows[p]));
            cols = eff_dim(cols_reg, DEF_MAX_COLS);
            rows = eff_dim(rows_reg, DEF_MAX_ROWS);
            for (int n = 0; n < ph_items[p]; n++) add_cmd(random_cmd(cols, rows));
            if (p == NUM_PHASES - 1) begin
                add_cmd(mk(CMD_SQUARE, 32, 0, 0, 0, 0, FACE_LU));
                add_cmd(mk(CMD_LINE, 0, 0, 31, 31, 0, FACE_LU));
            end
            settle();
        end

        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
